// ===== rtl/core/wbps_pkg.sv =====
// Package for the wildcard byte pattern search block.
// Shared constants, register indexes, and the result and configuration types.
// No dependencies.
`default_nettype none

package wbps_pkg;

  // stored pattern bytes, the width of the length register, and the APB data and address widths
  localparam int PAT_STORE = 32;
  localparam int LEN_W     = 6;
  localparam int CFG_DW    = 64;
  localparam int CFG_AW    = 6;

  // a pattern byte of this value matches anything
  localparam logic [7:0] WILDCARD = 8'h2A;

  typedef enum logic [2:0] {
    REG_LEN  = 3'd0,
    REG_PAT0 = 3'd1,
    REG_PAT1 = 3'd2,
    REG_PAT2 = 3'd3,
    REG_PAT3 = 3'd4,
    REG_BASE = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic        found;
    logic [31:0] addr;
  } wbps_res_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [31:0]      base;
  } wbps_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/wbps_cfg.sv =====
// Register file for the pattern search: APB-style writes and reads,
// plus the pattern realigned to window order. Depends on wbps_pkg.
`default_nettype none

module wbps_cfg
  import wbps_pkg::*;
#(
  parameter  int MAX_PATTERN = 32,
  localparam int CAP = (MAX_PATTERN < PAT_STORE) ? MAX_PATTERN : PAT_STORE
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_AW-1:0]     paddr,
  input  logic [CFG_DW-1:0]     pwdata,
  output logic [CFG_DW-1:0]     prdata,
  output wbps_cfg_t             cfg_o,
  output logic [CAP-1:0]        care_o,
  output logic [CAP-1:0][7:0]   apat_o
);

  logic [LEN_W-1:0]           plen_q;
  logic [3:0][63:0]           pat_q;
  logic [31:0]                base_q;
  logic [PAT_STORE-1:0][7:0]  pat;
  reg_idx_e                   idx;
  logic                       wr;

  logic [LEN_W-1:0]           len_d, len_q;
  logic [CAP-1:0]             care_d, care_q;
  logic [CAP-1:0][7:0]        apat_d, apat_q;

  assign pat = pat_q;
  assign idx = reg_idx_e'(paddr[5:3]);
  assign wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q <= LEN_W'(1);
      pat_q  <= '0;
      base_q <= '0;
    end else if (wr) begin
      case (idx)
        REG_LEN:  plen_q   <= pwdata[LEN_W-1:0];
        REG_PAT0: pat_q[0] <= pwdata;
        REG_PAT1: pat_q[1] <= pwdata;
        REG_PAT2: pat_q[2] <= pwdata;
        REG_PAT3: pat_q[3] <= pwdata;
        REG_BASE: base_q   <= pwdata[31:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_LEN:  prdata = {{(CFG_DW-LEN_W){1'b0}}, plen_q};
      REG_PAT0: prdata = pat_q[0];
      REG_PAT1: prdata = pat_q[1];
      REG_PAT2: prdata = pat_q[2];
      REG_PAT3: prdata = pat_q[3];
      REG_BASE: prdata = {32'd0, base_q};
      default:  prdata = '0;
    endcase
  end

  // effective length: zero reads as one, saturate at CAP
  always_comb begin
    if (plen_q == '0) begin
      len_d = LEN_W'(1);
    end else if (plen_q > LEN_W'(CAP)) begin
      len_d = LEN_W'(CAP);
    end else begin
      len_d = plen_q;
    end
  end

  // window slot k (newest = 0) lines up with pattern byte len-1-k
  always_comb begin
    int j;
    care_d = '0;
    apat_d = '0;
    for (int k = 0; k < CAP; k++) begin
      j = int'(len_d) - 1 - k;
      if (k < int'(len_d)) begin
        apat_d[k] = pat[j[4:0]];
        care_d[k] = (pat[j[4:0]] != WILDCARD);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= LEN_W'(1);
      care_q <= '0;
    end else begin
      len_q  <= len_d;
      care_q <= care_d;
    end
  end

  always_ff @(posedge clk_i) begin
    apat_q <= apat_d;
  end

  assign cfg_o.len  = len_q;
  assign cfg_o.base = base_q;
  assign care_o     = care_q;
  assign apat_o     = apat_q;

  ap_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q != '0 && len_q <= LEN_W'(CAP))
    else $error("effective pattern length out of range");

endmodule

`default_nettype wire

// ===== rtl/core/wbps_scan.sv =====
// Scan datapath: byte window, byte count, match flag and the window compare.
// Depends on wbps_pkg; pattern comes prealigned from wbps_cfg.
`default_nettype none

module wbps_scan
  import wbps_pkg::*;
#(
  parameter  int MAX_PATTERN = 32,
  parameter  int ADDR_BITS   = 32,
  localparam int CAP = (MAX_PATTERN < PAT_STORE) ? MAX_PATTERN : PAT_STORE
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  input  logic                last_i,
  input  wbps_cfg_t           cfg_i,
  input  logic [CAP-1:0]      care_i,
  input  logic [CAP-1:0][7:0] apat_i,
  output logic                res_valid_o,
  output wbps_res_t           res_o
);

  localparam int AMB = (ADDR_BITS < 32) ? ADDR_BITS : 32;
  localparam logic [31:0] ADDR_MASK = {32{1'b1}} >> (32 - AMB);

  logic [MAX_PATTERN-1:0][7:0] win_q, win_sh;
  logic [31:0]                 seen_q, seen_inc, offset;
  logic                        matched_q;
  logic                        hit;

  always_comb begin
    win_sh[0] = byte_i;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      win_sh[k] = win_q[k-1];
    end
  end

  assign seen_inc = (seen_q == '1) ? seen_q : seen_q + 32'd1;
  assign offset   = seen_inc - {{(32-LEN_W){1'b0}}, cfg_i.len};

  always_comb begin
    hit = (seen_inc >= {{(32-LEN_W){1'b0}}, cfg_i.len});
    for (int k = 0; k < CAP; k++) begin
      if (care_i[k] && (win_sh[k] != apat_i[k])) begin
        hit = 1'b0;
      end
    end
  end

  always_comb begin
    res_valid_o = 1'b0;
    res_o       = '0;
    if (!matched_q && hit) begin
      res_valid_o = 1'b1;
      res_o.found = 1'b1;
      res_o.addr  = (cfg_i.base + offset) & ADDR_MASK;
    end else if (!matched_q && last_i) begin
      res_valid_o = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q     <= '0;
      seen_q    <= '0;
      matched_q <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        win_q     <= '0;
        seen_q    <= '0;
        matched_q <= 1'b0;
      end else if (!matched_q) begin
        win_q     <= win_sh;
        seen_q    <= seen_inc;
        matched_q <= hit;
      end
    end
  end

  ap_one_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && matched_q |-> !res_valid_o)
    else $error("second result in one region");

  ap_fresh_region: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_i |=> seen_q == '0 && !matched_q)
    else $error("region state not cleared at region end");

endmodule

`default_nettype wire

// ===== rtl/core/wildcard_byte_pattern_search.sv =====
// Wildcard byte pattern search, top level.
// Input register, scan datapath (wbps_scan), result register, register file
// (wbps_cfg). Depends on wbps_pkg.
//
// Use: program pattern_length, the four pattern words and region_base over
// the APB port (64-bit data, register i at byte address 8*i), then stream the
// region's bytes in on s_axis, one item per byte, tlast on the final byte.
// A pattern byte of 0x2A matches any byte. Each region gives exactly one
// result item on m_axis: tuser=1 with the match start address on the byte
// that completes the first match, or tuser=0 with address 0 on the last byte
// when nothing matched. Bytes after a match are swallowed until tlast.
// A byte is accepted into the input register; its result item moves into
// the result register once that slot is free or draining. Throughput: one
// byte per cycle while m_axis keeps up, set by the combinational window
// compare; s_axis_tready stays high while a waiting result is held.
// When m_axis stalls, the result register and then the input register fill,
// and tready drops only once both are held. tready is also low during an
// APB write access phase so the realigned pattern is settled before use.
// Reset clears window, byte count and registers (length 1, others 0).
`default_nettype none

module wildcard_byte_pattern_search
  import wbps_pkg::*;
#(
  parameter int MAX_PATTERN = 32,
  parameter int ADDR_BITS   = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // APB-style configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  // byte stream in
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] data_byte
  input  logic              s_axis_tlast,   // region_last
  // result out
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [31:0]       m_axis_tdata,   // [31:0] match_address
  output logic              m_axis_tuser    // [0] found
);

  localparam int CAP = (MAX_PATTERN < PAT_STORE) ? MAX_PATTERN : PAT_STORE;

  wbps_cfg_t           cfg;
  logic [CAP-1:0]      care;
  logic [CAP-1:0][7:0] apat;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       adv, in_acc, cfg_busy;

  logic       res_valid;
  wbps_res_t  res;
  logic       out_valid_q;
  wbps_res_t  out_res_q;

  assign pready = 1'b1;

  wbps_cfg #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg),
    .care_o  (care),
    .apat_o  (apat)
  );

  // the input stage moves on whenever the result slot is free or draining;
  // only a step that yields a result fills the slot; other steps leave it to drain
  assign adv      = in_valid_q && (!out_valid_q || m_axis_tready);
  assign cfg_busy = psel && penable && pwrite;
  assign s_axis_tready = (!in_valid_q || adv) && !cfg_busy;
  assign in_acc   = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_acc) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  wbps_scan #(
    .MAX_PATTERN (MAX_PATTERN),
    .ADDR_BITS   (ADDR_BITS)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (adv),
    .byte_i      (in_byte_q),
    .last_i      (in_last_q),
    .cfg_i       (cfg),
    .care_i      (care),
    .apat_i      (apat),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res_valid) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_res_q.addr;
  assign m_axis_tuser  = out_res_q.found;

  ap_no_take_in_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_busy |-> !s_axis_tready)
    else $error("item taken during a register write");

  ap_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !adv |=> in_valid_q && $stable(in_byte_q) && $stable(in_last_q))
    else $error("input stage lost an item while stalled");

  ap_notfound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_res_q.found |-> out_res_q.addr == '0)
    else $error("not-found result carries an address");

endmodule

`default_nettype wire

// ===== verif/wbps_match_checker.sv =====
// Match checker for the wildcard byte pattern search block.
// Follows APB writes and both streams, predicts each region's result item
// and compares it with what leaves m_axis. Depends on wbps_pkg.
`default_nettype none

module wbps_match_checker
  import wbps_pkg::*;
#(
  parameter int MAX_PATTERN = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] data_byte
  input  logic              s_axis_tlast,   // region_last
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [31:0]       m_axis_tdata,   // [31:0] match_address
  input  logic              m_axis_tuser,   // [0] found
  output int                fail_count,
  output int                pending_count
);

  localparam int WIN        = (MAX_PATTERN < PAT_STORE) ? MAX_PATTERN : PAT_STORE;
  localparam int REPORT_MAX = 40;

  // shadow of the register file
  logic [LEN_W-1:0] len_cfg;
  logic [7:0]       pat_cfg [PAT_STORE];
  logic [31:0]      base_cfg;

  // scan state: newest byte at index 0
  logic [7:0]  recent [WIN];
  logic [31:0] seen;
  logic        matched;

  wbps_res_t expected_matches [$];

  task automatic report_mismatch(input string what);
    if (fail_count < REPORT_MAX)
      $display("[%0t] result mismatch: %s", $time, what);
    fail_count++;
  endtask

  task automatic restart_region();
    foreach (recent[k]) recent[k] = 8'h00;
    seen    = '0;
    matched = 1'b0;
  endtask

  task automatic apply_write(input logic [2:0] idx, input logic [CFG_DW-1:0] data);
    int first;
    case (reg_idx_e'(idx))
      REG_LEN:  len_cfg = data[LEN_W-1:0];
      REG_BASE: base_cfg = data[31:0];
      REG_PAT0, REG_PAT1, REG_PAT2, REG_PAT3: begin
        first = (int'(idx) - int'(REG_PAT0)) * 8;
        for (int k = 0; k < 8; k++) pat_cfg[first + k] = data[8*k +: 8];
      end
      default: ;  // beyond the register list: ignored
    endcase
  endtask

  // one byte of the region; queues the result item it causes, if any
  task automatic scan_byte(input logic [7:0] b, input logic last);
    int        n;
    logic      hit;
    wbps_res_t res;
    if (!matched) begin
      for (int k = WIN - 1; k > 0; k--) recent[k] = recent[k-1];
      recent[0] = b;
      if (seen != '1) seen++;
      // zero length acts as one, over-long saturates to the window
      n = int'(len_cfg);
      if (n == 0) n = 1;
      if (n > WIN) n = WIN;
      hit = (seen >= 32'(n));
      for (int i = 0; i < n; i++)
        if (pat_cfg[i] != WILDCARD && pat_cfg[i] != recent[n-1-i]) hit = 1'b0;
      if (hit) begin
        res.found = 1'b1;
        res.addr  = base_cfg + (seen - 32'(n));
        expected_matches = {expected_matches, res};
        matched = 1'b1;
      end
    end
    if (last) begin
      if (!matched) begin
        res.found = 1'b0;
        res.addr  = '0;
        expected_matches = {expected_matches, res};
      end
      restart_region();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    wbps_res_t want;
    if (!rst_ni) begin
      len_cfg  = LEN_W'(1);
      base_cfg = '0;
      foreach (pat_cfg[k]) pat_cfg[k] = 8'h00;
      restart_region();
      expected_matches.delete();
      fail_count = 0;
      pending_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready)
        apply_write(paddr[CFG_AW-1:3], pwdata);
      // a result never belongs to a byte taken at the same edge
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_matches.size() == 0) begin
          report_mismatch($sformatf("found=%0b addr=%h with nothing pending",
                                    m_axis_tuser, m_axis_tdata));
        end else begin
          want = expected_matches.pop_front();
          if (m_axis_tuser !== want.found)
            report_mismatch($sformatf("found %0b, predicted %0b", m_axis_tuser, want.found));
          if (m_axis_tdata !== want.addr)
            report_mismatch($sformatf("addr %h, predicted %h", m_axis_tdata, want.addr));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        scan_byte(s_axis_tdata, s_axis_tlast);
      pending_count <= expected_matches.size();
    end
  end

endmodule

`default_nettype wire

// ===== verif/tb_wildcard_byte_pattern_search.sv =====
// Testbench top for the wildcard byte pattern search block.
// Drives APB set-up and byte regions, paces the result sink and gives the
// verdict; checking sits in wbps_match_checker. Depends on wbps_pkg.
`default_nettype none

module tb_wildcard_byte_pattern_search;
  import wbps_pkg::*;

  localparam int RUN_ITEMS      = 420;   // stimulus stops once this many bytes are in and the hold-off phase has run
  localparam int HOLD_PHASE     = 4;     // phase in which the sink holds off
  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no item moving on either stream
  localparam int SETTLE_CYCLES  = 6;

  // addresses past the register list, written now and then; must be ignored
  localparam logic [2:0] SPARE_IDX_A = 3'd6;
  localparam logic [2:0] SPARE_IDX_B = 3'd7;

  typedef enum logic [1:0] {
    SINK_ALWAYS,
    SINK_RANDOM,
    SINK_PATTERN
  } sink_mode_e;

  logic              clk_i  = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [CFG_AW-1:0] paddr   = '0;
  logic [CFG_DW-1:0] pwdata  = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata  = 8'h00;  // [7:0] data_byte
  logic              s_axis_tlast  = 1'b0;   // region_last
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [31:0]       m_axis_tdata;           // [31:0] match_address
  logic              m_axis_tuser;           // [0] found

  int fail_count;
  int pending_count;

  // pacing of both sides
  sink_mode_e sink_mode    = SINK_ALWAYS;
  bit         hold_req     = 1'b0;
  bit         hold_done    = 1'b0;
  int         sink_tick    = 0;
  int         stall_cycles = 0;
  int         gap_max      = 0;
  int         burst_left   = 0;
  int         bytes_sent   = 0;

  // pattern as last programmed, used to build regions that match
  logic [7:0] pat_bytes [PAT_STORE];
  int         pat_len = 1;
  logic [7:0] region_q [$];

  wildcard_byte_pattern_search dut (.*);

  wbps_match_checker checker_i (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Result sink. A hold-off request pulls tready low for a long stretch
  // while the sender keeps offering, so the block fills and stalls s_axis.
  always @(posedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      m_axis_tready <= 1'b0;
      repeat (HOLD_CYCLES - 1) @(posedge clk_i);
    end else begin
      case (sink_mode)
        SINK_ALWAYS: m_axis_tready <= 1'b1;
        SINK_RANDOM: m_axis_tready <= ($urandom_range(0, 2) != 0);
        default: begin
          sink_tick++;
          m_axis_tready <= ((sink_tick % 5) < 2);
        end
      endcase
    end
  end

  // Watchdog: gives up once nothing has moved on either stream for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Two-phase APB write: setup, then access; pready is tied high but honoured.
  task automatic apb_write(input logic [2:0] idx, input logic [CFG_DW-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // One byte item. Bursts of random length, random gaps between bursts;
  // gap_max of zero gives back-to-back items.
  task automatic push_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_region();
    foreach (region_q[i]) push_byte(region_q[i], i == region_q.size() - 1);
  endtask

  // Stop offering, let every predicted result drain, then allow the
  // two-stage pipe to empty of bytes that give no result.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [7:0] filler_byte();
    if ($urandom_range(0, 1) != 0) return 8'($urandom);
    return pat_bytes[$urandom_range(0, PAT_STORE - 1)];  // near misses
  endfunction

  // mix of wildcards, corner values and random bytes
  task automatic fresh_pattern();
    int r;
    foreach (pat_bytes[k]) begin
      r = $urandom_range(0, 9);
      if (r < 3)      pat_bytes[k] = WILDCARD;
      else if (r == 3) pat_bytes[k] = 8'h00;
      else if (r == 4) pat_bytes[k] = 8'hFF;
      else if (r == 5) pat_bytes[k] = 8'h2B;
      else             pat_bytes[k] = 8'($urandom);
    end
  endtask

  // Writes every register; upper pwdata bits carry junk that must be dropped.
  task automatic program_search(input logic [LEN_W-1:0] len_code, input logic [31:0] base);
    logic [CFG_DW-1:0] word;
    pat_len = (len_code == 0) ? 1 : (int'(len_code) > PAT_STORE) ? PAT_STORE : int'(len_code);
    apb_write(REG_LEN, {32'($urandom), 26'($urandom), len_code});
    for (int w = 0; w < 4; w++) begin
      for (int k = 0; k < 8; k++) word[8*k +: 8] = pat_bytes[8*w + k];
      apb_write(3'(int'(REG_PAT0) + w), word);
    end
    apb_write(REG_BASE, {32'($urandom), base});
    if ($urandom_range(0, 3) == 0)
      apb_write(($urandom_range(0, 1) != 0) ? SPARE_IDX_A : SPARE_IDX_B,
                {32'($urandom), 32'($urandom)});
  endtask

  function automatic logic [LEN_W-1:0] pick_len_code(input int phase);
    int r;
    if (phase == 0) return LEN_W'(PAT_STORE);  // full window
    if (phase == 1) return LEN_W'(63);         // saturates to the window
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return LEN_W'(PAT_STORE);
    if (r == 2) return LEN_W'($urandom_range(PAT_STORE + 1, 63));
    if (r < 10) return LEN_W'($urandom_range(1, 3));
    return LEN_W'($urandom_range(4, 12));
  endfunction

  function automatic logic [31:0] pick_base();
    case ($urandom_range(0, 5))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'hFFFF_FFF0;  // wraps with a short offset
      default: return 32'($urandom);
    endcase
  endfunction

  // Region with random lead and tail. Mostly a full pattern instance with
  // wildcard slots filled at random; some broken off early; some pure noise.
  task automatic send_random_region();
    int kind;
    int lead;
    int keep;
    int tail;
    region_q.delete();
    kind = $urandom_range(0, 9);
    lead = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
    keep = (kind < 7) ? pat_len : (kind < 9) ? $urandom_range(0, pat_len - 1) : 0;
    tail = $urandom_range(0, 4);
    repeat (lead) region_q = {region_q, filler_byte()};
    for (int i = 0; i < keep; i++)
      region_q = {region_q, ((pat_bytes[i] == WILDCARD) ? filler_byte() : pat_bytes[i])};
    repeat (tail) region_q = {region_q, filler_byte()};
    if (region_q.size() == 0) region_q = {region_q, filler_byte()};
    send_region();
  endtask

  initial begin
    int stim_phase;
    foreach (pat_bytes[k]) pat_bytes[k] = 8'h00;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed. Reset settings: length 1, pattern byte 0x00, base 0.
    // Match on the region's last byte, then a region with no match.
    region_q = '{8'h55, 8'h00};
    send_region();
    region_q = '{8'hAA};
    send_region();
    wait_drained();

    // DE * AD FF from offset 3 above base FFFF_FFFE: address wraps to 1,
    // trailing byte after the match is swallowed
    fresh_pattern();
    pat_bytes[0] = 8'hDE;
    pat_bytes[1] = WILDCARD;
    pat_bytes[2] = 8'hAD;
    pat_bytes[3] = 8'hFF;
    program_search(LEN_W'(4), 32'hFFFF_FFFE);
    gap_max   = 3;
    sink_mode = SINK_RANDOM;
    region_q = '{8'h00, 8'h11, 8'h22, 8'hDE, 8'h7F, 8'hAD, 8'hFF, 8'h33};
    send_region();
    // regions shorter than the pattern, one of them a byte short of a match
    region_q = '{8'hDE, 8'h2A};
    send_region();
    region_q = '{8'hDE, 8'h2A, 8'hAD};
    send_region();
    wait_drained();

    // zero length acts as one; lone wildcard matches anything, 0x2A too
    pat_bytes[0] = WILDCARD;
    program_search('0, 32'hFFFF_FFFF);
    region_q = '{8'h2A};
    send_region();
    region_q = '{8'h00, 8'h2A};
    send_region();

    // Random phases: fresh settings each time, extremes in the first ones;
    // the hold-off phase always runs.
    stim_phase = 0;
    while (bytes_sent < RUN_ITEMS || stim_phase <= HOLD_PHASE) begin
      wait_drained();
      fresh_pattern();
      sink_mode = sink_mode_e'($urandom_range(0, 2));
      gap_max   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (stim_phase == HOLD_PHASE) begin
        // every one-byte region gives a result; with the sink held off the
        // block backs up and must stall its input
        pat_bytes[0] = WILDCARD;
        program_search(LEN_W'(1), pick_base());
        gap_max  = 0;
        hold_req = 1'b1;
        repeat (40) begin
          region_q = '{8'($urandom)};
          if ($urandom_range(0, 1) != 0) region_q = {region_q, 8'($urandom)};
          send_region();
        end
      end else begin
        program_search(pick_len_code(stim_phase), pick_base());
        repeat ($urandom_range(1, 4)) send_random_region();
      end
      stim_phase++;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/wbps_pkg.sv
rtl/core/wbps_cfg.sv
rtl/core/wbps_scan.sv
rtl/core/wildcard_byte_pattern_search.sv
verif/wbps_match_checker.sv
verif/tb_wildcard_byte_pattern_search.sv
